// ===== rtl/hexdec_pkg.sv =====
package hexdec_pkg;

   localparam int DEC_DIGITS = 20;
   localparam int IDX_W = $clog2(DEC_DIGITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEC_DIGITS - 1);

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;
   localparam logic [7:0] CHAR_UP_X   = 8'h58;
   localparam logic [7:0] CHAR_LO_X   = 8'h78;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_char;
      logic [1:0] status;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      logic       is_nul;
      logic       is_hex;
      logic       is_zero;
      logic       is_x;
      logic [3:0] nib;
   } char_class_type;

   typedef struct packed {
      logic [3:0] digit;
      logic [3:0] carry;
   } digit_step_type;

endpackage

// ===== rtl/hexdec_char_decode.sv =====
module hexdec_char_decode (
   input  logic [7:0]                  char_code,
   output hexdec_pkg::char_class_type  char_class
);
   import hexdec_pkg::*;

   logic [7:0] off_digit;
   logic [7:0] off_upper;
   logic [7:0] off_lower;
   logic       in_digit;
   logic       in_upper;
   logic       in_lower;

   always_comb begin
      off_digit = char_code - CHAR_ZERO;
      off_upper = char_code - CHAR_UP_A + 8'd10;
      off_lower = char_code - CHAR_LO_A + 8'd10;
      in_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      in_upper  = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F);
      in_lower  = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_F);

      char_class.is_nul  = (char_code == CHAR_NUL);
      char_class.is_hex  = in_digit || in_upper || in_lower;
      char_class.is_zero = (char_code == CHAR_ZERO);
      char_class.is_x    = (char_code == CHAR_UP_X) || (char_code == CHAR_LO_X);
      if (in_digit) begin
         char_class.nib = off_digit[3:0];
      end else if (in_upper) begin
         char_class.nib = off_upper[3:0];
      end else begin
         char_class.nib = off_lower[3:0];
      end
   end

endmodule

// ===== rtl/hexdec_digit_unit.sv =====
module hexdec_digit_unit (
   input  logic [3:0]                  digit_in,
   input  logic [3:0]                  carry_in,
   output hexdec_pkg::digit_step_type  step_out
);
   import hexdec_pkg::*;

   logic [7:0]  sum;
   logic [15:0] prod;
   logic [3:0]  quot;
   logic [7:0]  rem;

   // digit * 16 + carry, then split by 10 via reciprocal (205 / 2048)
   always_comb begin
      sum  = {digit_in, 4'b0000} + {4'b0000, carry_in};
      prod = {8'd0, sum} * 16'd205;
      quot = prod[14:11];
      rem  = sum - ({4'd0, quot} * 8'd10);
      step_out.digit = rem[3:0];
      step_out.carry = quot;
   end

endmodule

// ===== rtl/hex_ascii_to_decimal_ascii_core.sv =====
// busy: a hex digit keeps busy high after its accept edge while one multiply-by-16 and
//   decimal carry step runs per bcd digit; other non-final characters leave busy low
// flow: a hex digit finishes its steps before the next character is accepted
// last item: a top-down sweep of all bcd digits follows; result beats are registered,
//   leading zeros give no beat, an error gives a single final beat, the receiver cannot stall
// reset: synchronous, active high; clears the bcd register and all string state
module hex_ascii_to_decimal_ascii_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hexdec_pkg::req_type  req_item,
   output logic                 rsp_strobe,
   output hexdec_pkg::rsp_type  rsp_item
);
   import hexdec_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [3:0]       carry_ff, carry_in;
   logic [1:0]       pos_ff, pos_in;
   logic             fwz_ff, fwz_in;
   logic [1:0]       err_ff, err_in;
   logic             ended_ff, ended_in;
   logic             last_ff, last_in;
   logic             seen_ff, seen_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic [3:0]       bcd_ff [DEC_DIGITS];

   logic             bcd_wr;
   logic [3:0]       bcd_wr_data;
   logic [3:0]       cur_digit;
   logic             accept;
   logic             active;
   char_class_type   char_class;
   digit_step_type   step;

   hexdec_char_decode u_decode (
      .char_code  (req_item.char_code),
      .char_class (char_class)
   );

   hexdec_digit_unit u_digit (
      .digit_in (cur_digit),
      .carry_in (carry_ff),
      .step_out (step)
   );

   assign cur_digit  = bcd_ff[idx_ff];
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign active     = !ended_ff && (err_ff == STATUS_OK);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      pos_in        = pos_ff;
      fwz_in        = fwz_ff;
      err_in        = err_ff;
      ended_in      = ended_ff;
      last_in       = last_ff;
      seen_in       = seen_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      bcd_wr        = 1'b0;
      bcd_wr_data   = 4'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_item.last_char;
               idx_in  = '0;
               seen_in = 1'b0;
               if (req_item.last_char) begin
                  state_in = ST_EMIT;
                  idx_in   = LAST_IDX;
               end
               if (active) begin
                  if (char_class.is_nul) begin
                     ended_in = 1'b1;
                  end else begin
                     // prefix x only as second char after a leading zero
                     if (pos_ff == 2'd1 && fwz_ff && char_class.is_x) begin
                        err_in = err_ff;
                     end else if (char_class.is_hex) begin
                        state_in = ST_MUL;
                        idx_in   = '0;
                        carry_in = char_class.nib;
                     end else begin
                        err_in = STATUS_BAD_CHAR;
                     end
                     if (pos_ff == 2'd0) begin
                        fwz_in = char_class.is_zero;
                     end
                     if (pos_ff != 2'd2) begin
                        pos_in = pos_ff + 2'd1;
                     end
                  end
               end
            end
         end
         ST_MUL: begin
            bcd_wr      = 1'b1;
            bcd_wr_data = step.digit;
            carry_in    = step.carry;
            idx_in      = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               if (step.carry != 4'd0) begin
                  err_in = STATUS_OVERFLOW;
               end
               if (last_ff) begin
                  state_in = ST_EMIT;
                  idx_in   = LAST_IDX;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            // sweep from the top digit, clearing as we go
            bcd_wr      = 1'b1;
            bcd_wr_data = 4'd0;
            idx_in      = idx_ff - IDX_W'(1);
            if (cur_digit != 4'd0) begin
               seen_in = 1'b1;
            end
            rsp_in.last_out = (idx_ff == '0);
            if (err_ff != STATUS_OK) begin
               rsp_strobe_in     = (idx_ff == '0);
               rsp_in.digit_char = 8'd0;
               rsp_in.status     = err_ff;
            end else begin
               rsp_strobe_in     = seen_ff || (cur_digit != 4'd0) || (idx_ff == '0);
               rsp_in.digit_char = CHAR_ZERO + {4'd0, cur_digit};
               rsp_in.status     = STATUS_OK;
            end
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
               pos_in   = 2'd0;
               fwz_in   = 1'b0;
               err_in   = STATUS_OK;
               ended_in = 1'b0;
               last_in  = 1'b0;
               seen_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         carry_ff      <= 4'd0;
         pos_ff        <= 2'd0;
         fwz_ff        <= 1'b0;
         err_ff        <= STATUS_OK;
         ended_ff      <= 1'b0;
         last_ff       <= 1'b0;
         seen_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < DEC_DIGITS; i++) begin
            bcd_ff[i] <= 4'd0;
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         carry_ff      <= carry_in;
         pos_ff        <= pos_in;
         fwz_ff        <= fwz_in;
         err_ff        <= err_in;
         ended_ff      <= ended_in;
         last_ff       <= last_in;
         seen_ff       <= seen_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (bcd_wr) begin
            bcd_ff[idx_ff] <= bcd_wr_data;
         end
      end
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_err_beat_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status != STATUS_OK)
         |-> rsp_item.last_out && (rsp_item.digit_char == 8'd0))
      else $error("error beat not final or carries a digit");

   a_beat_from_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EMIT))
      else $error("result beat outside the output sweep");

   a_final_beat_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last_out |-> !busy)
      else $error("block still busy after final beat");

   a_mul_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (step.digit <= 4'd9))
      else $error("multiply step produced a non-decimal digit");
`endif

endmodule
